// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is held.
`define DSA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("slot allocator check failed");

// Next-cycle implication, sampled on clk, off while reset is held.
`define DSA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("slot allocator check failed");

`endif

// File: rtl/dsa_pkg.sv
// Types, constants and register map of the descriptor slot allocator.
package dsa_pkg;

	localparam int MAX_SLOTS   = 1024;
	localparam int POOL_COUNT  = 5;
	localparam int SLOT_W      = $clog2(MAX_SLOTS);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int PIDX_W      = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
	localparam int MEM_DEPTH   = POOL_COUNT * MAX_SLOTS;
	localparam int MEM_AW      = $clog2(MEM_DEPTH);

	localparam int KIND_W      = 2;
	localparam int POOL_W      = 3;
	localparam int INDEX_W     = 10;
	localparam int OFFSET_W    = 22;
	localparam int STATUS_W    = 2;
	localparam int CAP_W       = 11;
	localparam int STRIDE_W    = 13;
	localparam int STRIDE_REGS = 5;
	localparam int PROD_W      = INDEX_W + STRIDE_W;

	localparam int DATA_W      = 32;
	localparam int ADDR_W      = 5;
	localparam int REG_IW      = ADDR_W - 2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
	localparam logic [STRIDE_W-1:0] STRIDE_RESET [STRIDE_REGS] = '{
		STRIDE_W'(32), STRIDE_W'(32), STRIDE_W'(32), STRIDE_W'(32), STRIDE_W'(8)
	};

	// Register map: word index within the configuration space.
	localparam logic [REG_IW-1:0] REG_CAPACITY = REG_IW'(0);
	localparam logic [REG_IW-1:0] REG_STRIDE0  = REG_IW'(1);
	localparam logic [REG_IW-1:0] REG_STRIDE4  = REG_IW'(5);

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_FRAME = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_EXHAUSTED = 2'd1,
		STATUS_RANGE     = 2'd2,
		STATUS_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MULT,
		ST_HOLD
	} state_t;

endpackage

// File: rtl/descriptor_slot_allocator_top.sv
// Descriptor slot allocator: five slot pools with bump counters and freed-slot queues.
//
// One request word is taken at a time and answered by exactly one result word. After
// acceptance a request passes through EXEC, which looks up and updates the pool's
// counters and starts the freed-slot memory access, then MULT, which takes the memory
// read data and does the registered 10x13 slot-times-stride multiply, then HOLD, which
// moves the answer into the output register once that register is free, after which
// in_stall drops again. The block takes no new request until it is through with the
// last one; a result waiting in the output register does not block acceptance of the
// next request. Each pool's queue of freed slots is a ring of MAX_SLOTS entries in one
// shared synchronous memory; its contents need no clearing, as only written entries are
// ever popped. Frame start and clear act on all pools at once and answer status ok with
// zero fields. Configuration (capacity and the five strides) is to be written over the
// APB port only while the block is idle; the block itself does not enforce this.
// pready is always high.
module descriptor_slot_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dsa_pkg::KIND_W-1:0]    kind,
	input  logic [dsa_pkg::POOL_W-1:0]    pool,
	input  logic [dsa_pkg::INDEX_W-1:0]   slot_index,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dsa_pkg::INDEX_W-1:0]   given_index,
	output logic [dsa_pkg::OFFSET_W-1:0]  byte_offset,
	output logic [dsa_pkg::STATUS_W-1:0]  status,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dsa_pkg::ADDR_W-1:0]    paddr,
	input  logic [dsa_pkg::DATA_W-1:0]    pwdata,
	output logic [dsa_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import dsa_pkg::*;

	// ---------------- configuration registers ----------------
	logic [CAP_W-1:0]    cap_q;
	logic [STRIDE_W-1:0] stride_q [STRIDE_REGS];
	logic [REG_IW-1:0]   reg_idx;
	logic                cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			for (int i = 0; i < STRIDE_REGS; i++) begin
				stride_q[i] <= STRIDE_RESET[i];
			end
		end else if (cfg_wr) begin
			// Drop writes beyond the last register; keep only the register's width.
			if (reg_idx == REG_CAPACITY) begin
				cap_q <= pwdata[CAP_W-1:0];
			end else if (reg_idx >= REG_STRIDE0 && reg_idx <= REG_STRIDE4) begin
				stride_q[REG_IW'(reg_idx - REG_STRIDE0)] <= pwdata[STRIDE_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_CAPACITY) begin
			prdata = DATA_W'(cap_q);
		end else if (reg_idx >= REG_STRIDE0 && reg_idx <= REG_STRIDE4) begin
			prdata = DATA_W'(stride_q[REG_IW'(reg_idx - REG_STRIDE0)]);
		end
	end

	// ---------------- sequencer ----------------
	state_t state_q, state_d;
	logic   accept, exec_en, mult_en, out_load, out_free;
	logic   out_valid_q;

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid)  state_d = ST_EXEC;
			ST_EXEC:                state_d = ST_MULT;
			ST_MULT:                state_d = ST_HOLD;
			ST_HOLD: if (out_free)  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		exec_en  = 1'b0;
		mult_en  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_EXEC: exec_en  = 1'b1;
			ST_MULT: mult_en  = 1'b1;
			ST_HOLD: out_load = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the request word.
	logic [KIND_W-1:0]  kind_q;
	logic [POOL_W-1:0]  pool_q;
	logic [INDEX_W-1:0] slot_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			pool_q <= pool;
			slot_q <= slot_index;
		end
	end

	// ---------------- per-pool counters ----------------
	logic [CNT_W-1:0]  bump_q [POOL_COUNT];
	logic [SLOT_W-1:0] head_q [POOL_COUNT];
	logic [SLOT_W-1:0] tail_q [POOL_COUNT];
	logic [CNT_W-1:0]  fill_q [POOL_COUNT];

	logic              pool_ok;
	logic [PIDX_W-1:0] pidx;
	logic [CNT_W-1:0]  ucap;
	logic [CNT_W-1:0]  bump_cur, fill_cur;
	logic [SLOT_W-1:0] head_cur, tail_cur, head_nxt, tail_nxt;
	logic              do_pop, do_push, do_bump;
	logic [STATUS_W-1:0] stat_d;
	logic [STRIDE_W-1:0] stride_sel;

	assign pool_ok  = 32'(pool_q) < POOL_COUNT;
	assign pidx     = pool_ok ? PIDX_W'(pool_q) : '0;
	assign ucap     = (32'(cap_q) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(cap_q);
	assign bump_cur = bump_q[pidx];
	assign fill_cur = fill_q[pidx];
	assign head_cur = head_q[pidx];
	assign tail_cur = tail_q[pidx];
	assign head_nxt = (head_cur == SLOT_W'(MAX_SLOTS - 1)) ? '0 : head_cur + 1'b1;
	assign tail_nxt = (tail_cur == SLOT_W'(MAX_SLOTS - 1)) ? '0 : tail_cur + 1'b1;
	assign stride_sel = (32'(pool_q) < STRIDE_REGS) ? stride_q[pool_q] : '0;

	always_comb begin
		do_pop  = 1'b0;
		do_push = 1'b0;
		do_bump = 1'b0;
		stat_d  = STATUS_OK;
		unique case (kind_t'(kind_q))
			KIND_ALLOC: begin
				priority if (!pool_ok)             stat_d  = STATUS_EXHAUSTED;
				else if (fill_cur != '0)           do_pop  = 1'b1;
				else if (bump_cur < ucap)          do_bump = 1'b1;
				else                               stat_d  = STATUS_EXHAUSTED;
			end
			KIND_FREE: begin
				priority if (!pool_ok || 32'(slot_q) >= 32'(ucap)) stat_d = STATUS_RANGE;
				else if (fill_cur >= CNT_W'(MAX_SLOTS))           stat_d = STATUS_FULL;
				else                                               do_push = 1'b1;
			end
			KIND_FRAME, KIND_CLEAR: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_COUNT; i++) begin
				bump_q[i] <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (exec_en) begin
			if (kind_t'(kind_q) == KIND_FRAME || kind_t'(kind_q) == KIND_CLEAR) begin
				for (int i = 0; i < POOL_COUNT; i++) begin
					bump_q[i] <= '0;
				end
			end
			if (kind_t'(kind_q) == KIND_CLEAR) begin
				for (int i = 0; i < POOL_COUNT; i++) begin
					head_q[i] <= '0;
					tail_q[i] <= '0;
					fill_q[i] <= '0;
				end
			end
			if (do_bump) bump_q[pidx] <= bump_cur + 1'b1;
			if (do_pop) begin
				head_q[pidx] <= head_nxt;
				fill_q[pidx] <= fill_cur - 1'b1;
			end
			if (do_push) begin
				tail_q[pidx] <= tail_nxt;
				fill_q[pidx] <= fill_cur + 1'b1;
			end
		end
	end

	// ---------------- freed-slot memory ----------------
	// One request at a time touches the memory, so a read never overlaps a write.
	logic [SLOT_W-1:0] free_mem [MEM_DEPTH];
	logic [SLOT_W-1:0] mem_rdata_s1;
	logic [MEM_AW-1:0] pool_base, mem_raddr, mem_waddr;

	assign pool_base = MEM_AW'(MEM_AW'(pidx) * MEM_AW'(MAX_SLOTS));
	assign mem_raddr = MEM_AW'(pool_base + MEM_AW'(head_cur));
	assign mem_waddr = MEM_AW'(pool_base + MEM_AW'(tail_cur));

	always_ff @(posedge clk) begin
		if (exec_en && do_push) free_mem[mem_waddr] <= SLOT_W'(slot_q);
		if (exec_en && do_pop)  mem_rdata_s1 <= free_mem[mem_raddr];
	end

	// ---------------- stage 1: decision ----------------
	logic                from_mem_s1;
	logic [INDEX_W-1:0]  given_s1;
	logic [STRIDE_W-1:0] stride_s1;
	logic [STATUS_W-1:0] stat_s1;

	always_ff @(posedge clk) begin
		if (exec_en) begin
			from_mem_s1 <= do_pop;
			given_s1    <= do_bump ? INDEX_W'(bump_cur) : '0;
			stride_s1   <= (do_pop || do_bump) ? stride_sel : '0;
			stat_s1     <= stat_d;
		end
	end

	// ---------------- stage 2: offset multiply ----------------
	logic [INDEX_W-1:0]  given_mux;
	logic [PROD_W-1:0]   product;
	logic [INDEX_W-1:0]  given_s2;
	logic [OFFSET_W-1:0] offset_s2;
	logic [STATUS_W-1:0] stat_s2;

	assign given_mux = from_mem_s1 ? INDEX_W'(mem_rdata_s1) : given_s1;
	assign product   = PROD_W'(given_mux) * PROD_W'(stride_s1);

	always_ff @(posedge clk) begin
		if (mult_en) begin
			given_s2  <= given_mux;
			offset_s2 <= product[OFFSET_W-1:0];
			stat_s2   <= stat_s1;
		end
	end

	// ---------------- output register ----------------
	logic [INDEX_W-1:0]  given_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [STATUS_W-1:0] stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			given_q  <= given_s2;
			offset_q <= offset_s2;
			stat_q   <= stat_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign given_index = given_q;
	assign byte_offset = offset_q;
	assign status      = stat_q;

endmodule

// File: rtl/dsa_checker.sv
// Port-level checks of the descriptor slot allocator and their binding.
`include "assert_macros.svh"

module dsa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [dsa_pkg::INDEX_W-1:0]   given_index,
	input logic [dsa_pkg::OFFSET_W-1:0]  byte_offset,
	input logic [dsa_pkg::STATUS_W-1:0]  status
);
	import dsa_pkg::*;

	// A request keeps the engine busy for the following cycle.
	`DSA_ASSERT_NXT(busy_after_accept, in_valid && !in_stall, in_stall)

	// A stalled result word holds.
	`DSA_ASSERT_NXT(out_hold, out_valid && out_stall, out_valid && $stable(given_index) && $stable(byte_offset) && $stable(status))

	// No slot handed out on a failed request.
	`DSA_ASSERT_IMP(fail_zero, out_valid && status != STATUS_OK, given_index == '0 && byte_offset == '0)

	// Slot zero always lies at offset zero.
	`DSA_ASSERT_IMP(slot0_offset0, out_valid && given_index == '0, byte_offset == '0)

endmodule

bind descriptor_slot_allocator_top dsa_checker u_dsa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.given_index (given_index),
	.byte_offset (byte_offset),
	.status      (status)
);

// File: sim/descriptor_slot_allocator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the descriptor slot allocator: request driver, result checker, slot ledger.
module descriptor_slot_allocator_top_tb;
	import dsa_pkg::*;

	// Register index past the map: writes there must leave every register alone.
	localparam int REG_UNMAPPED = int'(REG_STRIDE4) + 1;
	// Cycles to let pass once the last result word is in, before touching the registers.
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 10;
	localparam int BURST_WORDS = 90;
	// Freed slots queued in one pool before the wide-stride pulls at the end.
	localparam int FLOOD_WORDS = 64;
	// Capacity for each random burst: tiny pools that run dry, the full heap, and
	// values above the heap size that must clip to it.
	localparam int PHASE_CAPACITY [9] = '{3, 1024, 17, 2047, 1, 200, 8, 1024, 5};

	typedef struct packed {
		logic [INDEX_W-1:0]  index;
		logic [OFFSET_W-1:0] offset;
		status_t             code;
	} answer_t;

	// Shadow of the allocator: configuration, bump counters, freed-slot rings, and the
	// answers still owed on the result channel.
	class slot_ledger;
		logic [CAP_W-1:0]    capacity;
		logic [STRIDE_W-1:0] stride [STRIDE_REGS];
		logic [CNT_W-1:0]    bump [POOL_COUNT];
		logic [SLOT_W-1:0]   head [POOL_COUNT];
		logic [SLOT_W-1:0]   tail [POOL_COUNT];
		logic [CNT_W-1:0]    fill [POOL_COUNT];
		logic [INDEX_W-1:0]  freed [POOL_COUNT][MAX_SLOTS];
		answer_t             awaited [$];
		int                  mismatches;
		int                  answered [4];

		function new();
			capacity = CAP_RESET;
			foreach (stride[i]) stride[i] = STRIDE_RESET[i];
			foreach (answered[i]) answered[i] = 0;
			mismatches = 0;
			clear_pools();
		endfunction

		function void clear_pools();
			foreach (bump[i]) begin
				bump[i] = '0;
				head[i] = '0;
				tail[i] = '0;
				fill[i] = '0;
			end
		endfunction

		function logic [CNT_W-1:0] usable();
			return (capacity > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : capacity;
		endfunction

		function logic [SLOT_W-1:0] advance(logic [SLOT_W-1:0] pos);
			return (pos == SLOT_W'(MAX_SLOTS - 1)) ? '0 : pos + 1'b1;
		endfunction

		function void report(string what);
			mismatches++;
			if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", what);
		endfunction

		function void set_register(int idx, logic [DATA_W-1:0] value);
			if (idx == REG_CAPACITY)
				capacity = value[CAP_W-1:0];
			else if (idx >= REG_STRIDE0 && idx <= REG_STRIDE4)
				stride[idx - REG_STRIDE0] = value[STRIDE_W-1:0];
		endfunction

		function void note_request(logic [KIND_W-1:0] k, logic [POOL_W-1:0] p,
				logic [INDEX_W-1:0] s);
			answer_t           a;
			logic [PROD_W-1:0] prod;
			logic [CNT_W-1:0]  lim;
			a = '0;
			a.code = STATUS_OK;
			lim = usable();
			case (kind_t'(k))
				KIND_ALLOC: begin
					if (p >= POOL_COUNT) begin
						a.code = STATUS_EXHAUSTED;
					end else if (fill[p] != 0) begin
						// oldest freed slot first, even if it now lies above the capacity
						a.index = freed[p][head[p]];
						head[p] = advance(head[p]);
						fill[p] = fill[p] - 1'b1;
					end else if (bump[p] < lim) begin
						a.index = bump[p][INDEX_W-1:0];
						bump[p] = bump[p] + 1'b1;
					end else begin
						a.code = STATUS_EXHAUSTED;
					end
					if (a.code == STATUS_OK) begin
						prod = a.index * stride[p];
						a.offset = prod[OFFSET_W-1:0];
					end
				end
				KIND_FREE: begin
					if (p >= POOL_COUNT || s >= lim) begin
						a.code = STATUS_RANGE;
					end else if (fill[p] >= MAX_SLOTS) begin
						a.code = STATUS_FULL;
					end else begin
						freed[p][tail[p]] = s;
						tail[p] = advance(tail[p]);
						fill[p] = fill[p] + 1'b1;
					end
				end
				KIND_FRAME: begin
					foreach (bump[i]) bump[i] = '0;
				end
				default: begin
					clear_pools();
				end
			endcase
			awaited.push_back(a);
		endfunction

		function void check_result(logic [INDEX_W-1:0] gi, logic [OFFSET_W-1:0] off,
				logic [STATUS_W-1:0] st);
			answer_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result word with nothing outstanding: index %0d offset %0d status %0d",
					gi, off, st));
				return;
			end
			want = awaited.pop_front();
			if (!$isunknown(st)) answered[st]++;
			if (gi !== want.index || off !== want.offset || st !== want.code)
				report($sformatf("expected index %0d offset %0d status %s, got index %0d offset %0d status %0d",
					want.index, want.offset, want.code.name(), gi, off, st));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [KIND_W-1:0]    kind = '0;
	logic [POOL_W-1:0]    pool = '0;
	logic [INDEX_W-1:0]   slot_index = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [INDEX_W-1:0]   given_index;
	logic [OFFSET_W-1:0]  byte_offset;
	logic [STATUS_W-1:0]  status;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	slot_ledger ledger;
	int         idle_pct = 14;
	int         stall_pct = 87;
	int         sent_words = 0;
	int         reg_writes = 0;

	descriptor_slot_allocator_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.pool        (pool),
		.slot_index  (slot_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.given_index (given_index),
		.byte_offset (byte_offset),
		.status      (status),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sample both channels on the edge itself: a request word is noted before any result
	// of the same edge is checked, so an answer given on the very edge of its request would still line up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				ledger.note_request(kind, pool, slot_index);
				sent_words++;
			end
			if (out_valid && !out_stall)
				ledger.check_result(given_index, byte_offset, status);
		end
	end

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	// Hang guard: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("run timed out with %0d result words still owed", ledger.awaited.size());
		$display("descriptor_slot_allocator_top regression: fail");
		$finish;
	end

	// Present one request word, after an optional idle gap, and hold it until taken.
	// Valid stays high on return so that back-to-back words need no extra edge.
	task automatic send(kind_t k, int p, int s);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		kind       <= k;
		pool       <= POOL_W'(p);
		slot_index <= INDEX_W'(s);
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and hold off until every owed result word is in, plus a settling margin.
	// The first edge lets the monitor note a word taken on the edge we returned from.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ledger.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write with junk in the bits above the register width, then read it back.
	task automatic write_register(int idx, int value, int width);
		logic [DATA_W-1:0] mask;
		logic [DATA_W-1:0] word;
		logic [DATA_W-1:0] want;
		mask = (width >= DATA_W) ? '1 : (DATA_W'(1) << width) - 1'b1;
		word = (DATA_W'($urandom) & ~mask) | (DATA_W'(value) & mask);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 4);
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ledger.set_register(idx, word);
		reg_writes++;
		// second transfer: read the same address back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_CAPACITY)
			want = DATA_W'(ledger.capacity);
		else if (idx <= REG_STRIDE4)
			want = DATA_W'(ledger.stride[idx - REG_STRIDE0]);
		if (idx <= REG_STRIDE4 && prdata !== want)
			ledger.report($sformatf("register %0d read back %0h, expected %0h", idx, prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly allocates and frees of slots inside the capacity, so the freed-slot rings fill
	// and drain; the rest are stray pools, out-of-range slots, frame starts and clears.
	task automatic random_burst(int count);
		int pick;
		int p;
		int s;
		int lim;
		repeat (count) begin
			pick = $urandom_range(99);
			p = ($urandom_range(9) == 0) ? $urandom_range(7, POOL_COUNT) : $urandom_range(POOL_COUNT - 1);
			lim = int'(ledger.usable());
			s = (lim > 0 && $urandom_range(3) != 0) ? $urandom_range(lim - 1) : $urandom_range(1023);
			if (pick < 47)
				send(KIND_ALLOC, p, $urandom_range(1023));
			else if (pick < 91)
				send(KIND_FREE, p, s);
			else if (pick < 97)
				send(KIND_FRAME, p, $urandom_range(1023));
			else
				send(KIND_CLEAR, p, $urandom_range(1023));
		end
	endtask

	initial begin
		int sv;
		ledger = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: bump hand-out, reuse in arrival order, stray pools.
		send(KIND_ALLOC, 0, 0);
		send(KIND_ALLOC, 4, 1023);
		send(KIND_ALLOC, 0, 0);
		send(KIND_FREE, 0, 1023);
		send(KIND_FREE, 0, 0);
		send(KIND_ALLOC, 0, 0);
		send(KIND_ALLOC, 0, 0);
		send(KIND_ALLOC, 0, 0);
		send(KIND_ALLOC, 5, 0);
		send(KIND_FREE, 7, 1023);
		send(KIND_FRAME, 0, 0);
		send(KIND_ALLOC, 0, 0);
		send(KIND_CLEAR, 6, 0);
		send(KIND_FREE, 2, 900);

		// Zero capacity: the queued slot still comes out, then the pool is dry.
		drain_results();
		write_register(REG_CAPACITY, 0, CAP_W);
		write_register(REG_STRIDE0, 4096, STRIDE_W);
		write_register(REG_STRIDE0 + 1, 1, STRIDE_W);
		write_register(REG_STRIDE0 + 3, 0, STRIDE_W);
		write_register(REG_STRIDE4, 8191, STRIDE_W);
		write_register(REG_UNMAPPED, $urandom, DATA_W);
		send(KIND_ALLOC, 1, 0);
		send(KIND_FREE, 1, 0);
		send(KIND_ALLOC, 2, 0);
		send(KIND_ALLOC, 2, 0);

		// Capacity above the heap: top slot, wrapped offset, zero and unit strides.
		drain_results();
		write_register(REG_CAPACITY, 2047, CAP_W);
		send(KIND_FREE, 4, 1023);
		send(KIND_ALLOC, 4, 0);
		send(KIND_ALLOC, 3, 0);
		send(KIND_ALLOC, 3, 0);
		send(KIND_ALLOC, 1, 0);
		send(KIND_ALLOC, 1, 0);

		// Two-slot pools: run out, and refuse a slot at the capacity.
		drain_results();
		write_register(REG_CAPACITY, 2, CAP_W);
		write_register(REG_STRIDE0 + 2, 32, STRIDE_W);
		send(KIND_ALLOC, 2, 0);
		send(KIND_ALLOC, 2, 0);
		send(KIND_ALLOC, 2, 0);
		send(KIND_FREE, 2, 2);

		// Random bursts under three idling regimes, new settings for each burst.
		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 3) begin
				idle_pct = 87;
				stall_pct = 14;
			end
			if (ph == 6) begin
				idle_pct = 0;
				stall_pct = 0;
			end
			drain_results();
			write_register(REG_CAPACITY, PHASE_CAPACITY[ph], CAP_W);
			for (int i = 0; i < STRIDE_REGS; i++) begin
				case ($urandom_range(7))
					0: sv = 0;
					1: sv = 1;
					2: sv = 4096;
					3: sv = 8191;
					default: sv = $urandom_range(4096, 1);
				endcase
				write_register(REG_STRIDE0 + i, sv, STRIDE_W);
			end
			random_burst(BURST_WORDS);
		end

		// Queue a run of freed slots in one pool, then pull large slots back out with the
		// widest stride so the offsets wrap.
		drain_results();
		write_register(REG_CAPACITY, MAX_SLOTS, CAP_W);
		write_register(REG_STRIDE0 + 3, 8191, STRIDE_W);
		repeat (FLOOD_WORDS) send(KIND_FREE, 3, $urandom_range(1023));
		repeat (6) send(KIND_ALLOC, 3, 0);
		send(KIND_FREE, 3, $urandom_range(1023));
		send(KIND_CLEAR, 0, 0);
		send(KIND_ALLOC, 3, 0);

		drain_results();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (ledger.awaited.size() != 0)
			ledger.report($sformatf("%0d result words never arrived", ledger.awaited.size()));

		$display("%0d request words across 14 settings (%0d register writes): ok %0d, exhausted %0d, out of range %0d, queue full %0d",
			sent_words, reg_writes, ledger.answered[STATUS_OK], ledger.answered[STATUS_EXHAUSTED],
			ledger.answered[STATUS_RANGE], ledger.answered[STATUS_FULL]);
		$display("idling: sender light and receiver heavy, then the reverse, then none; %0d mismatches",
			ledger.mismatches);
		if (ledger.mismatches == 0)
			$display("descriptor_slot_allocator_top regression: pass");
		else
			$display("descriptor_slot_allocator_top regression: fail");
		$finish;
	end

endmodule
